>>> src/byte_budget_lru_tile_cache_assert.svh
// Assertion macros shared by the checker files of the tile cache.
`ifndef BYTE_BUDGET_LRU_TILE_CACHE_ASSERT_SVH
`define BYTE_BUDGET_LRU_TILE_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tile cache check failed");

// The consequent must hold in the cycle after the antecedent.
`define BBLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tile cache check failed");

`endif

>>> src/bblc_pkg.sv
// Types, constants and codes shared by the tile cache modules.
package bblc_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int MAX_ZOOM    = 22;

    localparam int X_W      = 22;
    localparam int Y_W      = 22;
    localparam int ZOOM_W   = 5;
    localparam int KEY_W    = X_W + Y_W + ZOOM_W;
    localparam int BYTES_W  = 24;
    localparam int USAGE_W  = 32;
    localparam int COUNT_W  = 6;

    localparam logic [USAGE_W-1:0] BUDGET_RESET = 32'd67108864;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic KIND_EVICT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY,
        S_EVICT
    } state_t;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_MATCH,
        CMD_FRONT,
        CMD_DROP,
        CMD_EVICT,
        CMD_INSERT
    } cell_cmd_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [BYTES_W-1:0] bytes;
    } entry_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [KEY_W-1:0]   key;
        logic [BYTES_W-1:0] bytes;
    } cell_ctrl_t;

    typedef struct packed {
        logic               hit;
        logic [BYTES_W-1:0] hit_bytes;
        logic [KEY_W-1:0]   tail_key;
        logic [BYTES_W-1:0] tail_bytes;
    } chain_stat_t;

endpackage

>>> src/bblc_if.sv
// Request and result channel interfaces of the tile cache.
interface bblc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [bblc_pkg::X_W-1:0]      tile_x;
    logic [bblc_pkg::Y_W-1:0]      tile_y;
    logic [bblc_pkg::ZOOM_W-1:0]   zoom_level;
    logic [bblc_pkg::BYTES_W-1:0]  tile_bytes;

    modport source (
        output valid, opcode, tile_x, tile_y, zoom_level, tile_bytes,
        input  ready
    );
    modport sink (
        input  valid, opcode, tile_x, tile_y, zoom_level, tile_bytes,
        output ready
    );
endinterface

interface bblc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic                          hit;
    logic [bblc_pkg::X_W-1:0]      evicted_x;
    logic [bblc_pkg::Y_W-1:0]      evicted_y;
    logic [bblc_pkg::ZOOM_W-1:0]   evicted_zoom;
    logic [bblc_pkg::BYTES_W-1:0]  evicted_bytes;
    logic [bblc_pkg::USAGE_W-1:0]  usage_bytes;
    logic [bblc_pkg::COUNT_W-1:0]  entry_count;
    logic                          last;

    modport source (
        output valid, kind, hit, evicted_x, evicted_y, evicted_zoom, evicted_bytes,
               usage_bytes, entry_count, last,
        input  ready
    );
    modport sink (
        input  valid, kind, hit, evicted_x, evicted_y, evicted_zoom, evicted_bytes,
               usage_bytes, entry_count, last,
        output ready
    );
endinterface

>>> src/bblc_cell.sv
// One recency-ordered directory cell: holds an entry and trades it with its neighbors.
module bblc_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bblc_pkg::cell_ctrl_t ctrl,
    input  bblc_pkg::entry_t     left_ent,
    input  bblc_pkg::entry_t     right_ent,
    input  logic                 seen_l_in,
    input  logic                 seen_r_in,
    output logic                 seen_l_out,
    output logic                 seen_r_out,
    output bblc_pkg::entry_t     ent,
    output logic                 match,
    output logic                 tail
);

    logic                           valid_reg, valid_next;
    logic                           match_reg, match_next;
    logic [bblc_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [bblc_pkg::BYTES_W-1:0]   bytes_reg, bytes_next;

    // A cell is the tail when it is the last valid one in the row.
    assign tail       = valid_reg && !right_ent.valid;
    assign seen_l_out = seen_l_in || match_reg;
    assign seen_r_out = seen_r_in || match_reg;
    assign match      = match_reg;
    assign ent        = '{valid: valid_reg, key: key_reg, bytes: bytes_reg};

    always_comb
    begin
        valid_next = valid_reg;
        match_next = match_reg;
        key_next   = key_reg;
        bytes_next = bytes_reg;
        case (ctrl.cmd)
            bblc_pkg::CMD_MATCH:
            begin
                match_next = valid_reg && (key_reg == ctrl.key);
            end
            bblc_pkg::CMD_FRONT:
            begin
                // Every cell up to and including the hit moves one place back.
                if (seen_r_in || match_reg)
                begin
                    valid_next = left_ent.valid;
                    key_next   = left_ent.key;
                    bytes_next = left_ent.bytes;
                end
            end
            bblc_pkg::CMD_DROP:
            begin
                // The hit and every cell behind it close the gap.
                if (seen_l_in || match_reg)
                begin
                    valid_next = right_ent.valid;
                    key_next   = right_ent.key;
                    bytes_next = right_ent.bytes;
                end
            end
            bblc_pkg::CMD_EVICT:
            begin
                if (tail)
                begin
                    valid_next = 1'b0;
                end
            end
            bblc_pkg::CMD_INSERT:
            begin
                valid_next = left_ent.valid;
                key_next   = left_ent.key;
                bytes_next = left_ent.bytes;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        bytes_reg <= bytes_next;
    end

endmodule

>>> src/bblc_chain.sv
// Row of directory cells ordered from most recent to least recent.
module bblc_chain #(
    parameter int ENTRIES = bblc_pkg::ENTRIES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bblc_pkg::cell_ctrl_t    ctrl,
    output bblc_pkg::chain_stat_t   stat
);

    bblc_pkg::entry_t ent   [ENTRIES];
    bblc_pkg::entry_t head;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] tail_vec;
    logic [ENTRIES:0]   seen_l;
    logic [ENTRIES:0]   seen_r;

    // The item key enters the row at the most recent end.
    assign head      = '{valid: 1'b1, key: ctrl.key, bytes: ctrl.bytes};
    assign seen_l[0] = 1'b0;
    assign seen_r[ENTRIES] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        bblc_pkg::entry_t left_ent;
        bblc_pkg::entry_t right_ent;

        if (i == 0)
        begin : g_first
            assign left_ent = head;
        end
        else
        begin : g_inner_l
            assign left_ent = ent[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_last
            assign right_ent = '0;
        end
        else
        begin : g_inner_r
            assign right_ent = ent[i+1];
        end

        bblc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_ent   (left_ent),
            .right_ent  (right_ent),
            .seen_l_in  (seen_l[i]),
            .seen_r_in  (seen_r[i+1]),
            .seen_l_out (seen_l[i+1]),
            .seen_r_out (seen_r[i]),
            .ent        (ent[i]),
            .match      (match_vec[i]),
            .tail       (tail_vec[i])
        );
    end

    // Keys are unique and there is one tail, so both selections are one-hot.
    always_comb
    begin
        stat = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            stat.hit = stat.hit | match_vec[i];
            if (match_vec[i])
            begin
                stat.hit_bytes = stat.hit_bytes | ent[i].bytes;
            end
            if (tail_vec[i])
            begin
                stat.tail_key   = stat.tail_key | ent[i].key;
                stat.tail_bytes = stat.tail_bytes | ent[i].bytes;
            end
        end
    end

endmodule

>>> src/byte_budget_lru_tile_cache.sv
// Top level of the byte-budget LRU tile cache directory: sequencer, totals and result register.
// A lookup runs a match step, then an apply step that puts its status item in the result register.
// An insert runs match and apply, then one evict step per eviction notice and one for its status.
// Throughput: one item at a time; the next item is accepted once the sequencer is idle again,
// as the status is registered; a stalled result register holds the sequencer until it drains.
// Reset: all cells invalid, usage zero, budget 64 MiB; there is no clearing pass.
module byte_budget_lru_tile_cache #(
    parameter int ENTRIES = bblc_pkg::ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bblc_pkg::USAGE_W-1:0]   cfg_wr_data,
    bblc_req_if.sink                       req,
    bblc_rsp_if.source                     rsp
);

    // The count must be able to hold ENTRIES itself.
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam int X_LO = 0;
    localparam int Y_LO = bblc_pkg::X_W;
    localparam int Z_LO = bblc_pkg::X_W + bblc_pkg::Y_W;

    // Sequencer and item registers.
    bblc_pkg::state_t state_reg, state_next;
    logic                             op_reg;
    logic [bblc_pkg::KEY_W-1:0]       key_reg;
    logic [bblc_pkg::BYTES_W-1:0]     bytes_reg;
    logic                             item_hit_reg, item_hit_next;

    // Running totals of the directory and the budget register.
    logic [bblc_pkg::USAGE_W-1:0]     usage_reg, usage_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [bblc_pkg::USAGE_W-1:0]     budget_reg;

    // Result register.
    logic                             out_valid_reg;
    logic                             out_kind_reg;
    logic                             out_hit_reg;
    logic [bblc_pkg::KEY_W-1:0]       out_key_reg;
    logic [bblc_pkg::BYTES_W-1:0]     out_bytes_reg;
    logic [bblc_pkg::USAGE_W-1:0]     out_usage_reg;
    logic [bblc_pkg::COUNT_W-1:0]     out_count_reg;

    // Control toward the cell row and what it reports back.
    bblc_pkg::cell_ctrl_t             ctrl;
    bblc_pkg::chain_stat_t            stat;
    bblc_pkg::cell_cmd_t              cmd;
    logic [bblc_pkg::BYTES_W-1:0]     ctrl_bytes;

    logic                             out_free;
    logic                             over_budget;
    logic                             need_evict;
    logic                             emit;
    logic                             emit_kind;
    logic                             emit_hit;
    logic [bblc_pkg::KEY_W-1:0]       emit_key;
    logic [bblc_pkg::BYTES_W-1:0]     emit_bytes;
    logic [bblc_pkg::ZOOM_W-1:0]      zoom_sat;

    // The row of cells keeps entries packed from most recent (cell 0) to least recent.
    bblc_chain #(
        .ENTRIES (ENTRIES)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    assign ctrl = '{cmd: cmd, key: key_reg, bytes: ctrl_bytes};

    // Zoom levels beyond the deepest one are keyed as the deepest one.
    assign zoom_sat = (req.zoom_level > bblc_pkg::ZOOM_W'(bblc_pkg::MAX_ZOOM)) ?
                      bblc_pkg::ZOOM_W'(bblc_pkg::MAX_ZOOM) : req.zoom_level;

    assign req.ready = (state_reg == bblc_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // The eviction loop runs while the new tile would overflow the budget and entries remain,
    // and once more when every cell still holds another key.
    assign over_budget = ({1'b0, usage_reg} + (bblc_pkg::USAGE_W + 1)'(bytes_reg))
                         > {1'b0, budget_reg};
    assign need_evict  = ((count_reg != '0) && over_budget) ||
                         (count_reg == CNT_W'(ENTRIES));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bblc_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = bblc_pkg::S_MATCH;
                end
            end
            bblc_pkg::S_MATCH:
            begin
                state_next = bblc_pkg::S_APPLY;
            end
            bblc_pkg::S_APPLY:
            begin
                if (op_reg == bblc_pkg::OP_INSERT)
                begin
                    state_next = bblc_pkg::S_EVICT;
                end
                else if (out_free)
                begin
                    state_next = bblc_pkg::S_IDLE;
                end
            end
            bblc_pkg::S_EVICT:
            begin
                if (out_free && !need_evict)
                begin
                    state_next = bblc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bblc_pkg::S_IDLE;
            end
        endcase
    end

    // Cell commands, total updates and the result that goes out this cycle.
    always_comb
    begin
        cmd           = bblc_pkg::CMD_IDLE;
        ctrl_bytes    = bytes_reg;
        emit          = 1'b0;
        emit_kind     = bblc_pkg::KIND_STATUS;
        emit_hit      = 1'b0;
        emit_key      = '0;
        emit_bytes    = '0;
        usage_next    = usage_reg;
        count_next    = count_reg;
        item_hit_next = item_hit_reg;
        unique case (state_reg)
            bblc_pkg::S_IDLE:
            begin
            end
            bblc_pkg::S_MATCH:
            begin
                cmd = bblc_pkg::CMD_MATCH;
            end
            bblc_pkg::S_APPLY:
            begin
                if (op_reg == bblc_pkg::OP_LOOKUP)
                begin
                    // A hit moves to the front carrying its stored size.
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        emit_hit = stat.hit;
                        if (stat.hit)
                        begin
                            cmd        = bblc_pkg::CMD_FRONT;
                            ctrl_bytes = stat.hit_bytes;
                        end
                    end
                end
                else
                begin
                    // Replacing a key drops its old copy without a notice.
                    item_hit_next = stat.hit;
                    if (stat.hit)
                    begin
                        cmd        = bblc_pkg::CMD_DROP;
                        usage_next = usage_reg - bblc_pkg::USAGE_W'(stat.hit_bytes);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            bblc_pkg::S_EVICT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (need_evict)
                    begin
                        cmd        = bblc_pkg::CMD_EVICT;
                        emit_kind  = bblc_pkg::KIND_EVICT;
                        emit_key   = stat.tail_key;
                        emit_bytes = stat.tail_bytes;
                        usage_next = usage_reg - bblc_pkg::USAGE_W'(stat.tail_bytes);
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        cmd        = bblc_pkg::CMD_INSERT;
                        emit_hit   = item_hit_reg;
                        usage_next = usage_reg + bblc_pkg::USAGE_W'(bytes_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bblc_pkg::S_IDLE;
            usage_reg     <= '0;
            count_reg     <= '0;
            budget_reg    <= bblc_pkg::BUDGET_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            usage_reg <= usage_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                budget_reg <= cfg_wr_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        item_hit_reg <= item_hit_next;
        if (req.valid && req.ready)
        begin
            op_reg    <= req.opcode;
            key_reg   <= {zoom_sat, req.tile_y, req.tile_x};
            bytes_reg <= req.tile_bytes;
        end
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_hit_reg   <= emit_hit;
            out_key_reg   <= emit_key;
            out_bytes_reg <= emit_bytes;
            out_usage_reg <= usage_next;
            out_count_reg <= bblc_pkg::COUNT_W'(count_next);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.evicted_x     = out_key_reg[X_LO +: bblc_pkg::X_W];
    assign rsp.evicted_y     = out_key_reg[Y_LO +: bblc_pkg::Y_W];
    assign rsp.evicted_zoom  = out_key_reg[Z_LO +: bblc_pkg::ZOOM_W];
    assign rsp.evicted_bytes = out_bytes_reg;
    assign rsp.usage_bytes   = out_usage_reg;
    assign rsp.entry_count   = out_count_reg;
    assign rsp.last          = out_kind_reg;

endmodule

>>> src/bblc_checker.sv
// Port-level checker of the tile cache and its bind to the top level.
`include "byte_budget_lru_tile_cache_assert.svh"

module bblc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           out_kind,
    input logic [bblc_pkg::ZOOM_W-1:0]    out_zoom,
    input logic [bblc_pkg::USAGE_W-1:0]   out_usage
);

    // A stalled result keeps its contents.
    `BBLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_kind) && $stable(out_usage))

    // Items are worked one at a time: an accepted item closes the input for a while.
    `BBLC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    // While an eviction notice is shown, its insert is still in progress.
    `BBLC_ASSERT_SAME(a_notice_busy, clk, rst_n,
        out_valid && (out_kind == bblc_pkg::KIND_EVICT), !in_ready)

    // Evicted keys were stored with a saturated zoom level.
    `BBLC_ASSERT_SAME(a_notice_zoom, clk, rst_n,
        out_valid && (out_kind == bblc_pkg::KIND_EVICT),
        out_zoom <= bblc_pkg::ZOOM_W'(bblc_pkg::MAX_ZOOM))

endmodule

bind byte_budget_lru_tile_cache bblc_checker u_bblc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_kind  (rsp.kind),
    .out_zoom  (rsp.evicted_zoom),
    .out_usage (rsp.usage_bytes)
);
